@@ design/jdd_pkg.sv @@
`default_nettype none
package jdd_pkg;

  localparam int SAMPLE_BITS = 12;
  localparam int CFG_AW      = 4;
  localparam int CFG_DW      = 32;

  typedef logic [SAMPLE_BITS-1:0] sample_t;

  // event codes as they leave the block; directions double as stored state
  typedef enum logic [2:0] {
    EV_UP      = 3'd0,
    EV_DOWN    = 3'd1,
    EV_LEFT    = 3'd2,
    EV_RIGHT   = 3'd3,
    EV_CENTER  = 3'd4,
    EV_PRESS   = 3'd5,
    EV_RELEASE = 3'd6
  } evt_t;

  // register index, taken from paddr[3:2]
  typedef enum logic [1:0] {
    REG_THRESHOLD_HIGH = 2'd0,
    REG_THRESHOLD_LOW  = 2'd1,
    REG_CENTER_VALUE   = 2'd2
  } reg_idx_t;

  localparam sample_t THRESHOLD_HIGH_RST = sample_t'(3072);
  localparam sample_t THRESHOLD_LOW_RST  = sample_t'(1024);
  localparam sample_t CENTER_VALUE_RST   = sample_t'(2048);

endpackage
`default_nettype wire

@@ design/jdd_in_if.sv @@
`default_nettype none
interface jdd_in_if
  import jdd_pkg::*;
;
  logic    valid;
  logic    ready;
  sample_t x_sample;
  sample_t y_sample;
  logic    button;

  modport source (output valid, output x_sample, output y_sample, output button,
                  input ready);
  modport sink   (input valid, input x_sample, input y_sample, input button,
                  output ready);
endinterface
`default_nettype wire

@@ design/jdd_out_if.sv @@
`default_nettype none
interface jdd_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] event_code;
  logic       last;

  modport source (output valid, output event_code, output last, input ready);
  modport sink   (input valid, input event_code, input last, output ready);
endinterface
`default_nettype wire

@@ design/joystick_direction_event_detector.sv @@
// a sample goes from the input register to the result stage; throughput: one sample
//   per cycle while out_ch is ready and each raises at most one event; a sample with
//   a direction and a button event holds the stage until both leave, one per transfer
// reset (rst_n low, synchronous): thresholds and center back to 3072/1024/2048,
//   stored direction center, stored button released, both stages empty
`default_nettype none
module joystick_direction_event_detector
  import jdd_pkg::*;
(
  input  wire                clk,
  input  wire                rst_n,
  jdd_in_if.sink             in_ch,
  jdd_out_if.source          out_ch,
  input  wire                psel,
  input  wire                penable,
  input  wire                pwrite,
  input  wire [CFG_AW-1:0]   paddr,
  input  wire [CFG_DW-1:0]   pwdata,
  output logic [CFG_DW-1:0]  prdata,
  output logic               pready
);

  // configuration registers
  sample_t thr_high_r, thr_low_r, center_r;

  // input stage
  logic    s1_valid_r;
  sample_t s1_x_r, s1_y_r;
  logic    s1_btn_r;

  // stored state
  evt_t prev_dir_r;
  logic prev_btn_r;

  // result stage: up to two events, sel_r points at the one on display
  logic res_valid_r;
  evt_t ev0_r, ev1_r;
  logic has2_r, sel_r;

  // apb side: always ready, write lands on the access phase
  logic     cfg_wr;
  reg_idx_t cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_high_r <= THRESHOLD_HIGH_RST;
      thr_low_r  <= THRESHOLD_LOW_RST;
      center_r   <= CENTER_VALUE_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_THRESHOLD_HIGH: thr_high_r <= pwdata[SAMPLE_BITS-1:0];
        REG_THRESHOLD_LOW:  thr_low_r  <= pwdata[SAMPLE_BITS-1:0];
        REG_CENTER_VALUE:   center_r   <= pwdata[SAMPLE_BITS-1:0];
        default: ;  // unmapped address, write dropped
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (cfg_idx)
      REG_THRESHOLD_HIGH: prdata[SAMPLE_BITS-1:0] = thr_high_r;
      REG_THRESHOLD_LOW:  prdata[SAMPLE_BITS-1:0] = thr_low_r;
      REG_CENTER_VALUE:   prdata[SAMPLE_BITS-1:0] = center_r;
      default:            prdata = '0;
    endcase
  end

  // handshake between stages
  logic out_xfer, res_done, res_free, s1_move, in_xfer;

  assign out_xfer = out_ch.valid && out_ch.ready;
  assign res_done = out_xfer && out_ch.last;
  assign res_free = !res_valid_r || res_done;
  assign s1_move  = s1_valid_r && res_free;
  // the input register frees up as soon as its sample moves into the result stage
  assign in_ch.ready = !s1_valid_r || res_free;
  assign in_xfer  = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_x_r   <= in_ch.x_sample;
      s1_y_r   <= in_ch.y_sample;
      s1_btn_r <= in_ch.button;
    end
  end

  // dead-zone classification of the sample in the input register
  logic    xh, xl, yh, yl;
  sample_t dx, dy;
  evt_t    dir;

  always_comb begin
    xh  = s1_x_r > thr_high_r;
    xl  = s1_x_r < thr_low_r;
    yh  = s1_y_r > thr_high_r;
    yl  = s1_y_r < thr_low_r;
    dx  = (s1_x_r >= center_r) ? (s1_x_r - center_r) : (center_r - s1_x_r);
    dy  = (s1_y_r >= center_r) ? (s1_y_r - center_r) : (center_r - s1_y_r);
    dir = EV_CENTER;
    if (xh || xl || yh || yl) begin
      if (dx >= dy) begin
        // x wins ties; low x tested first when thresholds overlap
        if (xl)      dir = EV_RIGHT;
        else if (xh) dir = EV_LEFT;
      end else begin
        // high y tested first when thresholds overlap
        if (yh)      dir = EV_UP;
        else if (yl) dir = EV_DOWN;
      end
    end
  end

  // event list for this sample: direction change first, then button change
  logic dir_chg, btn_chg;
  evt_t btn_ev;

  assign dir_chg = (dir != prev_dir_r);
  assign btn_chg = (s1_btn_r != prev_btn_r);
  assign btn_ev  = s1_btn_r ? EV_PRESS : EV_RELEASE;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_dir_r <= EV_CENTER;
      prev_btn_r <= 1'b0;
    end else if (s1_move) begin
      prev_dir_r <= dir;
      prev_btn_r <= s1_btn_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
      sel_r       <= 1'b0;
      has2_r      <= 1'b0;
    end else if (s1_move) begin
      // a sample with no change leaves the result stage empty
      res_valid_r <= dir_chg || btn_chg;
      has2_r      <= dir_chg && btn_chg;
      sel_r       <= 1'b0;
    end else if (res_done) begin
      res_valid_r <= 1'b0;
    end else if (out_xfer) begin
      sel_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      ev0_r <= dir_chg ? dir : btn_ev;
      ev1_r <= btn_ev;
    end
  end

  assign out_ch.valid      = res_valid_r;
  assign out_ch.event_code = sel_r ? ev1_r : ev0_r;
  assign out_ch.last       = !has2_r || sel_r;

`ifndef NO_ASSERTIONS
  // first of two events is always taken over by the closing one
  a_second_event: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.ready && !out_ch.last |=> out_ch.valid && out_ch.last)
    else $error("second event missing after first transfer");

  // a non-final event can only be a direction event
  a_first_is_dir: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.last |->
      (out_ch.event_code != EV_PRESS) && (out_ch.event_code != EV_RELEASE))
    else $error("button event shown ahead of another event");

  // stored direction tracks the last committed classification
  a_prev_dir: assert property (@(posedge clk) disable iff (!rst_n)
    s1_move |=> prev_dir_r == $past(dir))
    else $error("stored direction not updated");

  // empty input register never stalls the input
  a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> in_ch.ready)
    else $error("input stalled with empty input register");
`endif

endmodule
`default_nettype wire

@@ verif/joystick_direction_event_detector_tb.sv @@
module joystick_direction_event_detector_tb;
  import jdd_pkg::*;

  // address slot past the last register, writes there must not land anywhere
  localparam logic [1:0] REG_UNMAPPED = 2'd3;
  localparam int SAMPLE_MAX      = (1 << SAMPLE_BITS) - 1;
  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 250;
  localparam int HOLD_CYCLES     = 300;
  // drain margin so that the last sample, which may raise nothing, passes through both stages
  localparam int DRAIN_CYCLES    = 6;

  typedef struct packed {
    sample_t x;
    sample_t y;
    logic    button;
  } sample_rec_t;

  typedef struct packed {
    evt_t code;
    logic last;
  } event_rec_t;

  logic              clk;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  jdd_in_if  in_if ();
  jdd_out_if out_if ();

  joystick_direction_event_detector u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_if),
    .out_ch  (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // samples waiting for the driver, events waiting for the monitor
  sample_rec_t pending_samples[$];
  event_rec_t  expected_events[$];

  // mirror of the block's registers and stored state
  sample_t thr_high_q;
  sample_t thr_low_q;
  sample_t center_q;
  evt_t    held_dir;
  logic    held_button;

  int   error_count;
  int   samples_queued;
  int   samples_taken;
  logic in_fire;      // input transfer seen at the last rising edge
  int   in_gap;
  int   out_stall;
  logic rx_blocked;   // long receiver hold-off for back-pressure
  logic steady;       // no idling on either side

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    #2000000;
    $display("** joystick_direction_event_detector: FAILED **");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  // classify one sample against the mirrored registers and queue the events it raises
  task automatic predict_events(input sample_rec_t s);
    logic xh, xl, yh, yl;
    int   dx, dy;
    evt_t dir;
    logic dir_change, btn_change;
    xh = s.x > thr_high_q;
    xl = s.x < thr_low_q;
    yh = s.y > thr_high_q;
    yl = s.y < thr_low_q;
    dx = (s.x >= center_q) ? int'(s.x) - int'(center_q) : int'(center_q) - int'(s.x);
    dy = (s.y >= center_q) ? int'(s.y) - int'(center_q) : int'(center_q) - int'(s.y);
    dir = EV_CENTER;
    if (xh || xl || yh || yl) begin
      // larger deflection wins, tie goes to x; low x tested first, high y tested first
      if (dx >= dy) begin
        if (xl) dir = EV_RIGHT;
        else if (xh) dir = EV_LEFT;
      end else begin
        if (yh) dir = EV_UP;
        else if (yl) dir = EV_DOWN;
      end
    end
    dir_change = (dir != held_dir);
    btn_change = (s.button != held_button);
    if (dir_change) begin
      expected_events.push_back('{dir, !btn_change});
      held_dir = dir;
    end
    if (btn_change) begin
      expected_events.push_back('{s.button ? EV_PRESS : EV_RELEASE, 1'b1});
      held_button = s.button;
    end
  endtask

  // mostly back-to-back, some short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  // input driver, changes only at the falling edge
  always @(negedge clk) begin
    sample_rec_t s;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      in_gap      <= 0;
    end else if (in_if.valid && !in_fire) begin
      // hold the offered sample until it transfers
    end else if (in_gap > 0) begin
      in_if.valid    <= 1'b0;
      in_gap         <= in_gap - 1;
      // payload noise while idle, must be ignored
      in_if.x_sample <= sample_t'($urandom);
      in_if.y_sample <= sample_t'($urandom);
      in_if.button   <= 1'($urandom);
    end else if (pending_samples.size() != 0) begin
      s = pending_samples.pop_front();
      in_if.valid    <= 1'b1;
      in_if.x_sample <= s.x;
      in_if.y_sample <= s.y;
      in_if.button   <= s.button;
      in_gap         <= pick_gap();
    end else begin
      in_if.valid <= 1'b0;
    end
  end

  // result receiver
  always @(negedge clk) begin
    if (!rst_n || rx_blocked) begin
      out_if.ready <= 1'b0;
    end else if (out_stall > 0) begin
      out_if.ready <= 1'b0;
      out_stall    <= out_stall - 1;
    end else begin
      out_if.ready <= 1'b1;
      out_stall    <= pick_gap();
    end
  end

  // monitor: predict on every input transfer, check every result transfer
  always @(posedge clk) begin
    event_rec_t want;
    if (!rst_n) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= in_if.valid && in_if.ready;
      if (in_if.valid && in_if.ready) begin
        predict_events('{in_if.x_sample, in_if.y_sample, in_if.button});
        samples_taken++;
      end
      if (out_if.valid && out_if.ready) begin
        if (expected_events.size() == 0) begin
          report_mismatch($sformatf("unexpected event code %0d last %0b",
                                    out_if.event_code, out_if.last));
        end else begin
          want = expected_events.pop_front();
          if (out_if.event_code !== want.code)
            report_mismatch($sformatf("event_code got %0d expected %0d",
                                      out_if.event_code, want.code));
          if (out_if.last !== want.last)
            report_mismatch($sformatf("last got %0b expected %0b", out_if.last, want.last));
        end
      end
    end
  end

  // two-phase register write, upper data bits are junk and must be dropped
  task automatic write_reg(input logic [1:0] idx, input int unsigned value);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    case (idx)
      REG_THRESHOLD_HIGH: thr_high_q = sample_t'(value);
      REG_THRESHOLD_LOW:  thr_low_q  = sample_t'(value);
      REG_CENTER_VALUE:   center_q   = sample_t'(value);
      default: ;
    endcase
  endtask

  task automatic set_config(input int hi, input int lo, input int ctr);
    write_reg(REG_THRESHOLD_HIGH, ($urandom & ~32'hfff) | hi);
    write_reg(REG_THRESHOLD_LOW, ($urandom & ~32'hfff) | lo);
    write_reg(REG_CENTER_VALUE, ($urandom & ~32'hfff) | ctr);
    write_reg(REG_UNMAPPED, $urandom);
  endtask

  task automatic queue_sample(input int x, input int y, input logic b);
    pending_samples.push_back('{sample_t'(x), sample_t'(y), b});
    samples_queued++;
  endtask

  // block idle: every sample transferred, every event back, pipeline flushed
  task automatic wait_idle();
    do @(negedge clk); while (samples_taken != samples_queued || expected_events.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // axis readings clustered around the interesting points of the current setting
  function automatic int pick_axis();
    int v;
    case ($urandom_range(0, 6))
      0, 1: v = $urandom_range(0, SAMPLE_MAX);
      2:    v = int'(thr_high_q) + int'($urandom_range(0, 6)) - 3;
      3:    v = int'(thr_low_q) + int'($urandom_range(0, 6)) - 3;
      4:    v = int'(center_q) + int'($urandom_range(0, 16)) - 8;
      5:    v = $urandom_range(0, 1) ? SAMPLE_MAX : 0;
      default: v = $urandom_range(0, 1) ? $urandom_range(0, 40)
                                         : SAMPLE_MAX - int'($urandom_range(0, 40));
    endcase
    if (v < 0) v = 0;
    if (v > SAMPLE_MAX) v = SAMPLE_MAX;
    return v;
  endfunction

  task automatic queue_random_sample();
    int x, y;
    x = pick_axis();
    y = pick_axis();
    // mirror x around center now and then to force equal deflection
    if ($urandom_range(0, 9) == 0) begin
      y = 2 * int'(center_q) - x;
      if (y < 0 || y > SAMPLE_MAX) y = pick_axis();
    end
    queue_sample(x, y, 1'($urandom_range(0, 1)));
  endtask

  initial begin
    rst_n          = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    in_if.valid    = 1'b0;
    in_if.x_sample = '0;
    in_if.y_sample = '0;
    in_if.button   = 1'b0;
    out_if.ready   = 1'b0;
    rx_blocked     = 1'b0;
    steady         = 1'b0;
    error_count    = 0;
    samples_queued = 0;
    samples_taken  = 0;
    in_fire        = 1'b0;
    in_gap         = 0;
    out_stall      = 0;
    thr_high_q     = THRESHOLD_HIGH_RST;
    thr_low_q      = THRESHOLD_LOW_RST;
    center_q       = CENTER_VALUE_RST;
    held_dir       = EV_CENTER;
    held_button    = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed, reset thresholds: each direction, press/release, exact thresholds, ties
    queue_sample(2048, 2048, 1'b0);        // rest, nothing raised
    queue_sample(0, 2048, 1'b0);           // low x gives right
    queue_sample(0, 2048, 1'b1);           // press only
    queue_sample(SAMPLE_MAX, 2048, 1'b1);  // high x gives left
    queue_sample(2048, SAMPLE_MAX, 1'b0);  // up plus release
    queue_sample(2048, 0, 1'b0);           // down
    queue_sample(1023, 3073, 1'b0);        // equal deflection, x wins
    queue_sample(3072, 1024, 1'b1);        // on the thresholds counts as center
    queue_sample(3073, 2048, 1'b1);
    queue_sample(1024, 3072, 1'b0);
    queue_sample(SAMPLE_MAX, 0, 1'b1);     // y deflects one more than x
    queue_sample(0, SAMPLE_MAX, 1'b0);
    queue_sample(0, 0, 1'b0);
    wait_idle();

    // off-center rest point: winning axis can sit inside the dead zone
    set_config(3072, 1024, 3500);
    queue_sample(1000, SAMPLE_MAX, 1'b1);  // x wins, right
    queue_sample(3000, 3100, 1'b1);        // x wins but inside, center
    queue_sample(3400, 3073, 1'b0);        // y wins, up
    queue_sample(3000, 3100, 1'b0);
    wait_idle();

    // crossed thresholds: one reading is both low and high
    set_config(1000, 3000, 2048);
    queue_sample(2000, 2048, 1'b1);        // x wins, low tested first, right
    queue_sample(2048, 2000, 1'b1);        // y wins, high tested first, up
    queue_sample(2048, 2048, 1'b0);        // tie at zero deflection, x, right
    queue_sample(SAMPLE_MAX, SAMPLE_MAX, 1'b1);
    wait_idle();

    // random phases over several settings, extremes first
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: set_config(3072, 1024, 2048);
        1: set_config(SAMPLE_MAX, 0, 2048);        // nothing ever deflects
        2: set_config(0, SAMPLE_MAX, 0);           // every reading deflects; all but 0 and SAMPLE_MAX deflect both ways
        3: set_config(2048, 2048, SAMPLE_MAX);
        default: set_config($urandom_range(0, SAMPLE_MAX), $urandom_range(0, SAMPLE_MAX),
                            $urandom_range(0, SAMPLE_MAX));
      endcase
      @(posedge clk);
      steady     = (p == 4);
      rx_blocked = (p == 5);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) queue_random_sample();
      if (rx_blocked) begin
        // results back up while samples keep coming, input must stall
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_blocked = 1'b0;
      end
      wait_idle();
      @(posedge clk);
      steady = 1'b0;
    end

    if (error_count == 0) begin
      $display("** joystick_direction_event_detector: PASSED **");
    end else begin
      $display("** joystick_direction_event_detector: FAILED **");
    end
    $finish;
  end

endmodule

@@ joystick_direction_event_detector.f @@
design/jdd_pkg.sv
design/jdd_in_if.sv
design/jdd_out_if.sv
design/joystick_direction_event_detector.sv
verif/joystick_direction_event_detector_tb.sv
